// ===== src/sfr_pkg.sv =====
// Shared types and constants for the sync frame receiver.
package sfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  typedef struct packed {
    logic       packet_ready;
    logic       checksum_bad;
    logic [7:0] frame_length;
    phase_t     parser_state;
  } result_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic       rd_sel;
    logic [7:0] rd_addr;
  } mem_req_t;

endpackage

// ===== src/sfr_if.sv =====
// Valid/ready channel interfaces for input and result beats.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output op, output rx_byte, output read_index, input ready);
  modport sink   (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       packet_ready;
  logic       checksum_bad;
  logic [7:0] frame_length;
  logic [2:0] parser_state;
  logic [7:0] read_data;

  modport source (output valid, output packet_ready, output checksum_bad,
                  output frame_length, output parser_state, output read_data, input ready);
  modport sink   (input valid, input packet_ready, input checksum_bad,
                  input frame_length, input parser_state, input read_data, output ready);
endinterface

// ===== src/sfr_parser.sv =====
// Frame parser state machine with running XOR and buffer access requests.
module sfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       read_index,
  output sfr_pkg::result_t result,
  output sfr_pkg::mem_req_t mem_req
);
  import sfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] pos_inc;

  assign pos_inc = pos_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    if (op == OP_RX) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (rx_byte == SYNC_SECOND) phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt   = rx_byte;
          pos_nxt   = '0;
          xor_nxt   = rx_byte;
          phase_nxt = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          xor_nxt = xor_r ^ rx_byte;
          pos_nxt = pos_inc;
          if (pos_inc == len_r) phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    result.packet_ready = 1'b0;
    result.checksum_bad = 1'b0;
    result.frame_length = len_nxt;
    result.parser_state = phase_nxt;
    if (op == OP_RX && phase_r == PH_CHECK) begin
      result.packet_ready = ((xor_r ^ rx_byte) == 8'd0);
      result.checksum_bad = ((xor_r ^ rx_byte) != 8'd0);
    end
    mem_req.wr_en   = accept && op == OP_RX && phase_r == PH_PAYLOAD;
    mem_req.wr_addr = pos_r;
    mem_req.wr_data = rx_byte;
    mem_req.rd_en   = accept;
    mem_req.rd_sel  = (op == OP_READ);
    mem_req.rd_addr = read_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      pos_r   <= '0;
      xor_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

// ===== src/sfr_payload_mem.sv =====
// Payload buffer: one write port, one registered read port.
module sfr_payload_mem #(
  parameter int BUF_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::mem_req_t mem_req,
  output logic [7:0]        rd_data
);
  import sfr_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] q_r;
  logic       hit_r;
  logic       wr_in_range;
  logic       rd_in_range;

  assign wr_in_range = {1'b0, mem_req.wr_addr} < 9'(BUF_DEPTH);
  assign rd_in_range = {1'b0, mem_req.rd_addr} < 9'(BUF_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_req.wr_en && wr_in_range) begin
      mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      q_r <= mem[mem_req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (mem_req.rd_en) begin
      hit_r <= mem_req.rd_sel && rd_in_range;
    end
  end

  assign rd_data = hit_r ? q_r : 8'd0;

endmodule

// ===== src/sync_frame_receiver_xor_check_unit.sv =====
// Top level of the two-byte sync deframer with XOR checksum.
// An accepted input beat's result is held in s1_res_r, then in s2_res_r at the output.
// Throughput: one beat per cycle unless stalled; one buffer write and read per cycle.
// A stalled output holds one result and one more in flight before input ready drops.
// Reset clears parser state and pipeline valids; the payload buffer is not cleared.
module sync_frame_receiver_xor_check_unit #(
  parameter int BUF_DEPTH = 256
) (
  input  logic    clk,
  input  logic    rst_n,
  sfr_in_if.sink  in_ch,
  sfr_out_if.source out_ch
);
  import sfr_pkg::*;

  result_t    res;
  mem_req_t   mem_req;
  logic [7:0] rd_data;
  logic       accept;
  logic       s2_load;

  logic       s1_valid_r, s1_valid_nxt;
  result_t    s1_res_r;
  logic       s2_valid_r, s2_valid_nxt;
  result_t    s2_res_r;
  logic [7:0] s2_rdata_r;

  assign s2_load     = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign accept      = in_ch.valid && in_ch.ready;

  sfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_ch.op),
    .rx_byte    (in_ch.rx_byte),
    .read_index (in_ch.read_index),
    .result     (res),
    .mem_req    (mem_req)
  );

  sfr_payload_mem #(.BUF_DEPTH(BUF_DEPTH)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (s2_load) s1_valid_nxt = 1'b0;
    s2_valid_nxt = s2_valid_r;
    if (s2_load) s2_valid_nxt = 1'b1;
    else if (out_ch.ready) s2_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_res_r <= res;
    if (s2_load) begin
      s2_res_r   <= s1_res_r;
      s2_rdata_r <= rd_data;
    end
  end

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.packet_ready = s2_res_r.packet_ready;
  assign out_ch.checksum_bad = s2_res_r.checksum_bad;
  assign out_ch.frame_length = s2_res_r.frame_length;
  assign out_ch.parser_state = s2_res_r.parser_state;
  assign out_ch.read_data    = s2_rdata_r;

endmodule

// ===== src/sfr_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_packet_ready,
  input logic       out_checksum_bad,
  input logic [2:0] out_parser_state,
  input logic [7:0] out_read_data
);
  import sfr_pkg::*;

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_packet_ready && out_checksum_bad))
    else $error("packet_ready and checksum_bad both set");

  a_check_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_packet_ready || out_checksum_bad) |->
      out_parser_state == PH_HUNT && out_read_data == 8'd0)
    else $error("checksum beat did not return parser to hunt");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parser_state)
      && $stable(out_read_data))
    else $error("stalled result beat changed");

endmodule

bind sync_frame_receiver_xor_check_unit sfr_checker u_sfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_packet_ready (out_ch.packet_ready),
  .out_checksum_bad (out_ch.checksum_bad),
  .out_parser_state (out_ch.parser_state),
  .out_read_data    (out_ch.read_data)
);

// ===== tb/sv/sync_frame_receiver_xor_check_unit_tb.sv =====
// Testbench for the sync frame receiver: predicts each result beat and checks it field by field.
`timescale 1ns / 1ps

module sync_frame_receiver_xor_check_unit_tb;
  import sfr_pkg::*;

  localparam int BUF_DEPTH   = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       pkt_ok;
    logic       pkt_bad;
    logic [7:0] len;
    phase_t     phase;
    logic [7:0] rdata;
  } deframe_beat_t;

  logic clk;
  logic rst_n;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  sync_frame_receiver_xor_check_unit #(
    .BUF_DEPTH(BUF_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Parser copy
  phase_t     cur_phase;
  logic [7:0] frame_len;
  logic [7:0] pay_pos;
  logic [7:0] xor_acc;
  logic [7:0] pay_buf [BUF_DEPTH];
  bit         stored [BUF_DEPTH];
  int         stored_list[$];

  deframe_beat_t pending_results[$];
  deframe_beat_t exp_beat;

  int mismatches;
  int cycle_count;
  int beats_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic deframe_beat_t deframe_predict(logic op, logic [7:0] b, logic [7:0] idx);
    deframe_beat_t r;
    r = '0;
    if (op == OP_READ) begin
      if (int'(idx) < BUF_DEPTH) r.rdata = pay_buf[idx];
    end else begin
      case (cur_phase)
        PH_HUNT: if (b == SYNC_FIRST) cur_phase = PH_SYNC1;
        PH_SYNC1: if (b == SYNC_SECOND) cur_phase = PH_LENGTH;
        PH_LENGTH: begin
          frame_len = b;
          pay_pos   = 8'd0;
          xor_acc   = b;
          cur_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (int'(pay_pos) < BUF_DEPTH) begin
            pay_buf[pay_pos] = b;
            if (!stored[pay_pos]) begin
              stored[pay_pos] = 1'b1;
              stored_list.insert(stored_list.size(), int'(pay_pos));
            end
          end
          xor_acc = xor_acc ^ b;
          pay_pos = pay_pos + 8'd1;
          if (pay_pos == frame_len) cur_phase = PH_CHECK;
        end
        PH_CHECK: begin
          if ((xor_acc ^ b) == 8'd0) r.pkt_ok = 1'b1;
          else r.pkt_bad = 1'b1;
          cur_phase = PH_HUNT;
        end
        default: cur_phase = PH_HUNT;
      endcase
    end
    r.len   = frame_len;
    r.phase = cur_phase;
    return r;
  endfunction

  function automatic logic [7:0] payload_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    if (roll < 25) return SYNC_FIRST;
    if (roll < 30) return SYNC_SECOND;
    return 8'($urandom_range(255));
  endfunction

  function automatic int frame_len_pick();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic send_beat(logic op, logic [7:0] b, logic [7:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.rx_byte    <= b;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    pending_results.insert(pending_results.size(), deframe_predict(op, b, idx));
  endtask

  task automatic send_rx(logic [7:0] b);
    send_beat(OP_RX, b, 8'($urandom_range(255)));
  endtask

  task automatic send_stored_read();
    if (stored_list.size() == 0) return;
    send_beat(OP_READ, 8'($urandom_range(255)),
              8'(stored_list[$urandom_range(stored_list.size() - 1)]));
  endtask

  task automatic send_frame(int len, bit good, bit garble);
    logic [7:0] sum;
    logic [7:0] b;
    send_rx(SYNC_FIRST);
    if (garble) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(255));
        if (b == SYNC_SECOND) b = 8'h00;
        send_rx(b);
      end
    end
    send_rx(SYNC_SECOND);
    send_rx(8'(len));
    sum = 8'(len);
    for (int i = 0; i < len; i++) begin
      b   = payload_byte();
      sum = sum ^ b;
      send_rx(b);
    end
    if (!good) sum = sum ^ 8'($urandom_range(1, 255));
    send_rx(sum);
  endtask

  task automatic check_field(string name, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cycle %0d %s: expected %0h, got %0h", cycle_count, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("cycle %0d: result beat with none pending", cycle_count);
      end else begin
        exp_beat = pending_results.pop_front();
        check_field("packet_ready", 8'(exp_beat.pkt_ok), 8'(out_ch.packet_ready));
        check_field("checksum_bad", 8'(exp_beat.pkt_bad), 8'(out_ch.checksum_bad));
        check_field("frame_length", exp_beat.len, out_ch.frame_length);
        check_field("parser_state", 8'(exp_beat.phase), 8'(out_ch.parser_state));
        check_field("read_data", exp_beat.rdata, out_ch.read_data);
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic test_directed();
    send_rx(8'h00);
    send_rx(8'hFF);
    // hold in sync wait on a wrong second byte
    send_rx(SYNC_FIRST);
    send_rx(8'h12);
    send_rx(SYNC_FIRST);
    send_rx(SYNC_SECOND);
    send_rx(8'd2);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'd2 ^ 8'hFF);
    send_beat(OP_READ, 8'hFF, 8'd0);
    send_beat(OP_READ, 8'h00, 8'd1);
    send_frame(0, 1'b1, 1'b0);
    send_frame(0, 1'b0, 1'b0);
    send_frame(1, 1'b0, 1'b0);
    // stale entry past the last frame length
    send_beat(OP_READ, 8'h00, 8'd1);
  endtask

  task automatic test_random_traffic(int items);
    int start;
    int roll;
    start = beats_sent;
    while (beats_sent - start < items) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        send_frame(frame_len_pick(), $urandom_range(99) < 75, 1'b0);
      end else if (roll < 65) begin
        send_frame(frame_len_pick(), $urandom_range(99) < 75, 1'b1);
      end else if (roll < 82) begin
        repeat ($urandom_range(1, 3)) send_stored_read();
      end else if (roll < 90) begin
        send_rx(SYNC_FIRST);
        send_rx(SYNC_SECOND);
        send_rx(8'($urandom_range(2, 6)));
        send_rx(payload_byte());
      end else begin
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_max_length();
    send_frame(255, 1'b1, 1'b0);
    send_beat(OP_READ, 8'h00, 8'd254);
    send_beat(OP_READ, 8'hFF, 8'd0);
  endtask

  task automatic test_output_stall();
    stall_left = 60;
    repeat (3) send_frame(4, 1'b1, 1'b0);
    repeat (4) send_stored_read();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_RX;
    in_ch.rx_byte    = 8'h00;
    in_ch.read_index = 8'h00;
    cur_phase        = PH_HUNT;
    frame_len        = 8'd0;
    pay_pos          = 8'd0;
    xor_acc          = 8'd0;
    mismatches       = 0;
    cycle_count      = 0;
    beats_sent       = 0;
    stall_left       = 0;
    send_idle_pct    = 16;
    recv_idle_pct    = 78;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(200);
    send_idle_pct = 78;
    recv_idle_pct = 16;
    test_random_traffic(200);
    test_max_length();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_traffic(200);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
